// ===== hw/rtl/json_byte_lexer_assert.svh =====
// ----------------------------------------------------------------------------
// JSON byte lexer assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_LEXER_ASSERT_SVH
`define JSON_BYTE_LEXER_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define JBL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_byte_lexer: same-cycle check failed");

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define JBL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_byte_lexer: next-cycle check failed");

`endif

// ===== hw/rtl/jbl_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON byte lexer package
// Shared types, token codes and sizes for the lexer front, queue and back.
// ----------------------------------------------------------------------------
package jbl_pkg;

    // Width of the line and column counters.
    localparam int POS_BITS = 24;
    typedef logic [POS_BITS-1:0] pos_t;
    localparam pos_t POS_MAX = '1;
    localparam pos_t POS_ONE = pos_t'(1);

    // Most results that one input byte can cause.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam logic [CNT_W-1:0] RES_MAX_CNT = CNT_W'(MAX_RES);

    // Queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Event codes.
    localparam logic EV_VALUE = 1'b0;
    localparam logic EV_DONE  = 1'b1;

    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_LBRACKET = 4'd2,
        TK_RBRACKET = 4'd3,
        TK_COLON    = 4'd4,
        TK_COMMA    = 4'd5,
        TK_STRING   = 4'd6,
        TK_NUMBER   = 4'd7,
        TK_TRUE     = 4'd8,
        TK_FALSE    = 4'd9,
        TK_NULL     = 4'd10,
        TK_ERROR    = 4'd11,
        TK_EOF      = 4'd12
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_STRING   = 3'd1,
        MODE_ESCAPE   = 3'd2,
        MODE_INTEGER  = 3'd3,
        MODE_FRACTION = 3'd4,
        MODE_WORD     = 3'd5
    } mode_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic       event_kind;
        logic [3:0] token_kind;
        logic [7:0] value_byte;
        pos_t       start_line;
        pos_t       start_column;
        logic       last_result;
    } out_item_t;

    // All results of one input byte, as held in the queue.
    typedef struct packed {
        logic [CNT_W-1:0]              count;
        out_item_t [MAX_RES-1:0]       res;
    } q_entry_t;

endpackage

// ===== hw/rtl/jbl_front.sv =====
// ----------------------------------------------------------------------------
// JSON byte lexer front
// Accepts text bytes, runs the lexer state and builds the list of results
// that each byte causes, which it pushes into the queue.
// ----------------------------------------------------------------------------
module jbl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  jbl_pkg::in_item_t    byte_data,
    input  logic                 q_full,
    output logic                 push,
    output jbl_pkg::q_entry_t    push_data
);

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Keyword table: true, false, null.
    localparam logic [7:0] KW_TEXT [3][5] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65},
        '{8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00}
    };
    localparam logic [2:0] KW_LEN [3] = '{3'd4, 3'd5, 3'd4};
    localparam logic [3:0] KW_KIND [3] = '{jbl_pkg::TK_TRUE, jbl_pkg::TK_FALSE,
                                           jbl_pkg::TK_NULL};
    localparam logic [2:0] KW_ALL = 3'b111;
    localparam logic [2:0] KW_LEN_MAX = 3'd7;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] ch);
        logic [7:0] r;
        r = 8'h00;
        case (ch)
            CH_QUOTE: r = CH_QUOTE;
            CH_BSL:   r = CH_BSL;
            CH_SLASH: r = CH_SLASH;
            8'h62:    r = 8'h08;
            8'h66:    r = 8'h0C;
            8'h6E:    r = 8'h0A;
            8'h72:    r = 8'h0D;
            8'h74:    r = 8'h09;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    // Drops keywords that no longer match and counts the letter.
    function automatic logic [5:0] kw_step(input logic [2:0] cd, input logic [2:0] kl,
                                           input logic [7:0] ch);
        logic [2:0] nc;
        logic [2:0] nk;
        nc = cd;
        for (int k = 0; k < 3; k++) begin
            if (cd[k] && ((kl >= KW_LEN[k]) || (KW_TEXT[k][kl] != ch))) begin
                nc[k] = 1'b0;
            end
        end
        nk = (kl < KW_LEN_MAX) ? kl + 3'd1 : kl;
        return {nc, nk};
    endfunction

    // Kind of a finished letter run.
    function automatic logic [3:0] kw_result(input logic [2:0] cd, input logic [2:0] kl);
        logic [3:0] r;
        r = jbl_pkg::TK_ERROR;
        for (int k = 2; k >= 0; k--) begin
            if (cd[k] && (kl == KW_LEN[k])) begin
                r = KW_KIND[k];
            end
        end
        return r;
    endfunction

    function automatic jbl_pkg::out_item_t mk(input logic ev, input logic [3:0] kind,
                                              input logic [7:0] val,
                                              input jbl_pkg::pos_t ln,
                                              input jbl_pkg::pos_t cl);
        jbl_pkg::out_item_t r;
        r.event_kind   = ev;
        r.token_kind   = kind;
        r.value_byte   = val;
        r.start_line   = ln;
        r.start_column = cl;
        r.last_result  = 1'b0;
        return r;
    endfunction

    // Lexer state.
    jbl_pkg::mode_t mode_reg, mode_next;
    logic [2:0]     cand_reg, cand_next;
    logic [2:0]     klen_reg, klen_next;
    jbl_pkg::pos_t  line_reg, line_next;
    jbl_pkg::pos_t  col_reg, col_next;
    jbl_pkg::pos_t  tok_line_reg, tok_line_next;
    jbl_pkg::pos_t  tok_col_reg, tok_col_next;
    logic           stopped_reg, stopped_next;

    // Working values of one byte step.
    jbl_pkg::mode_t                             step_mode;
    logic [2:0]                                 step_cand;
    logic [2:0]                                 step_klen;
    jbl_pkg::pos_t                              step_line;
    jbl_pkg::pos_t                              step_col;
    jbl_pkg::pos_t                              step_tl;
    jbl_pkg::pos_t                              step_tc;
    logic [jbl_pkg::CNT_W-1:0]                  step_n;
    jbl_pkg::out_item_t [jbl_pkg::MAX_RES-1:0]  step_res;
    logic                                       step_stop;

    logic accept;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full && !stopped_reg;

    // One byte through the lexer: results in order and the state it leaves.
    always_comb
    begin : lex_step
        logic [7:0] c;
        logic [7:0] e;
        logic       again;
        logic       pk_hit;
        logic [3:0] pk_kind;

        c         = byte_data.in_byte;
        e         = unescape(c);
        again     = 1'b0;
        pk_hit    = 1'b0;
        pk_kind   = jbl_pkg::TK_ERROR;
        step_mode = mode_reg;
        step_cand = cand_reg;
        step_klen = klen_reg;
        step_line = line_reg;
        step_col  = col_reg;
        step_tl   = tok_line_reg;
        step_tc   = tok_col_reg;
        step_n    = '0;
        step_res  = '0;
        step_stop = 1'b0;

        unique case (c)
            CH_LBRACE: begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_LBRACE;   end
            CH_RBRACE: begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_RBRACE;   end
            CH_LBRACK: begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_LBRACKET; end
            CH_RBRACK: begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_RBRACKET; end
            CH_COLON:  begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_COLON;    end
            CH_COMMA:  begin pk_hit = 1'b1; pk_kind = jbl_pkg::TK_COMMA;    end
            default:   begin pk_hit = 1'b0; pk_kind = jbl_pkg::TK_ERROR;    end
        endcase

        if (c != CH_NUL) begin
            // Continue or close the token in progress.
            unique case (step_mode) inside
                jbl_pkg::MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_DONE, jbl_pkg::TK_STRING, 8'h00, step_tl, step_tc);
                        step_n    = step_n + 1'b1;
                        step_mode = jbl_pkg::MODE_IDLE;
                    end else if (c == CH_BSL) begin
                        step_mode = jbl_pkg::MODE_ESCAPE;
                    end else begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_STRING, c, step_tl, step_tc);
                        step_n = step_n + 1'b1;
                    end
                end
                jbl_pkg::MODE_ESCAPE: begin
                    if (e == 8'h00) begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_DONE, jbl_pkg::TK_ERROR, 8'h00, step_tl, step_tc);
                        step_n    = step_n + 1'b1;
                        step_mode = jbl_pkg::MODE_IDLE;
                    end else begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_STRING, e, step_tl, step_tc);
                        step_n    = step_n + 1'b1;
                        step_mode = jbl_pkg::MODE_STRING;
                    end
                end
                jbl_pkg::MODE_INTEGER, jbl_pkg::MODE_FRACTION: begin
                    if (is_digit(c) ||
                        ((c == CH_DOT) && (step_mode == jbl_pkg::MODE_INTEGER))) begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_NUMBER, c, step_tl, step_tc);
                        step_n = step_n + 1'b1;
                        if (c == CH_DOT) begin
                            step_mode = jbl_pkg::MODE_FRACTION;
                        end
                    end else begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_DONE, jbl_pkg::TK_NUMBER, 8'h00, step_tl, step_tc);
                        step_n    = step_n + 1'b1;
                        step_mode = jbl_pkg::MODE_IDLE;
                        again     = 1'b1;
                    end
                end
                jbl_pkg::MODE_WORD: begin
                    if (is_alpha(c)) begin
                        {step_cand, step_klen} = kw_step(step_cand, step_klen, c);
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_ERROR, c, step_tl, step_tc);
                        step_n = step_n + 1'b1;
                    end else begin
                        step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                            mk(jbl_pkg::EV_DONE, kw_result(step_cand, step_klen), 8'h00,
                               step_tl, step_tc);
                        step_n    = step_n + 1'b1;
                        step_mode = jbl_pkg::MODE_IDLE;
                        again     = 1'b1;
                    end
                end
                default: begin
                    step_mode = jbl_pkg::MODE_IDLE;
                    again     = 1'b1;
                end
            endcase

            // Open a new token from idle.
            if (again && !is_space(c)) begin
                step_tl = step_line;
                step_tc = step_col;
                if (pk_hit) begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_VALUE, pk_kind, c, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_DONE, pk_kind, 8'h00, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                end else if (c == CH_QUOTE) begin
                    step_mode = jbl_pkg::MODE_STRING;
                end else if ((c == CH_MINUS) || is_digit(c)) begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_NUMBER, c, step_tl, step_tc);
                    step_n    = step_n + 1'b1;
                    step_mode = jbl_pkg::MODE_INTEGER;
                end else if (is_alpha(c)) begin
                    {step_cand, step_klen} = kw_step(KW_ALL, 3'd0, c);
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_ERROR, c, step_tl, step_tc);
                    step_n    = step_n + 1'b1;
                    step_mode = jbl_pkg::MODE_WORD;
                end else begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_VALUE, jbl_pkg::TK_ERROR, c, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_DONE, jbl_pkg::TK_ERROR, 8'h00, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                end
            end

            // Advance the position, saturating.
            if (c == CH_LF) begin
                if (step_line != jbl_pkg::POS_MAX) begin
                    step_line = step_line + jbl_pkg::POS_ONE;
                end
                step_col = jbl_pkg::POS_ONE;
            end else if (step_col != jbl_pkg::POS_MAX) begin
                step_col = step_col + jbl_pkg::POS_ONE;
            end
        end

        // End of input: close any open token, then the EOF beat.
        if ((c == CH_NUL) || byte_data.end_of_text) begin
            case (step_mode) inside
                jbl_pkg::MODE_STRING, jbl_pkg::MODE_ESCAPE: begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_DONE, jbl_pkg::TK_ERROR, 8'h00, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                end
                jbl_pkg::MODE_INTEGER, jbl_pkg::MODE_FRACTION: begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_DONE, jbl_pkg::TK_NUMBER, 8'h00, step_tl, step_tc);
                    step_n = step_n + 1'b1;
                end
                jbl_pkg::MODE_WORD: begin
                    step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                        mk(jbl_pkg::EV_DONE, kw_result(step_cand, step_klen), 8'h00,
                           step_tl, step_tc);
                    step_n = step_n + 1'b1;
                end
                default: begin
                end
            endcase
            step_mode = jbl_pkg::MODE_IDLE;
            step_res[step_n[jbl_pkg::IDX_W-1:0]] =
                mk(jbl_pkg::EV_DONE, jbl_pkg::TK_EOF, 8'h00, step_line, step_col);
            step_n    = step_n + 1'b1;
            step_stop = 1'b1;
        end
    end

    // Next state: taken only when a beat is accepted.
    always_comb
    begin
        mode_next     = mode_reg;
        cand_next     = cand_reg;
        klen_next     = klen_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        stopped_next  = stopped_reg;
        if (accept) begin
            mode_next     = step_mode;
            cand_next     = step_cand;
            klen_next     = step_klen;
            line_next     = step_line;
            col_next      = step_col;
            tok_line_next = step_tl;
            tok_col_next  = step_tc;
            stopped_next  = step_stop;
        end
    end

    // Outputs: a queue entry for every accepted byte that has results.
    always_comb
    begin
        push            = accept && (step_n != '0);
        push_data.count = step_n;
        push_data.res   = step_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= jbl_pkg::MODE_IDLE;
            cand_reg     <= KW_ALL;
            klen_reg     <= 3'd0;
            line_reg     <= jbl_pkg::POS_ONE;
            col_reg      <= jbl_pkg::POS_ONE;
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            cand_reg     <= cand_next;
            klen_reg     <= klen_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

// ===== hw/rtl/jbl_queue.sv =====
// ----------------------------------------------------------------------------
// JSON byte lexer queue
// Two-entry queue of per-byte result lists between the front and the back.
// ----------------------------------------------------------------------------
module jbl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jbl_pkg::q_entry_t push_data,
    output logic              q_full,
    input  logic              pop,
    output logic              q_nonempty,
    output jbl_pkg::q_entry_t head
);

    jbl_pkg::q_entry_t                 entry_reg [jbl_pkg::QDEPTH];
    logic [jbl_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [jbl_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [jbl_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;

    assign q_full     = (cnt_reg == jbl_pkg::QCNT_W'(jbl_pkg::QDEPTH));
    assign q_nonempty = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/jbl_back.sv =====
// ----------------------------------------------------------------------------
// JSON byte lexer back
// Walks the head queue entry's results one beat per cycle while unstalled
// into the output register and marks the last beat of each input byte.
// ----------------------------------------------------------------------------
module jbl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_nonempty,
    input  jbl_pkg::q_entry_t  head,
    output logic               pop,
    output logic               token_valid,
    input  logic               token_stall,
    output jbl_pkg::out_item_t token_data
);

    logic [jbl_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    jbl_pkg::out_item_t        data_reg, data_next;
    logic                      load;
    logic                      is_last;

    assign is_last     = ({1'b0, idx_reg} + 1'b1) == head.count;
    assign load        = q_nonempty && (!valid_reg || !token_stall);
    assign pop         = load && is_last;
    assign token_valid = valid_reg;
    assign token_data  = data_reg;

    // Select the next beat and step through the entry.
    always_comb
    begin
        data_next  = data_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && token_stall;
        if (load) begin
            data_next             = head.res[idx_reg];
            data_next.last_result = is_last;
            valid_next            = 1'b1;
            idx_next              = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/json_byte_lexer.sv =====
// ----------------------------------------------------------------------------
// JSON byte lexer
// Each byte's results go into a queue entry, then one by one into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and token_stall is
// low; the output register sends one result per cycle while unstalled, a byte's results
// in turn. The two-entry queue between the lexer and the output stage absorbs bursts.
// Reset (asynchronous, active low) sets line and column to one, empties the queue
// and the output; no clearing pass.
// ----------------------------------------------------------------------------
`include "json_byte_lexer_assert.svh"

module json_byte_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  jbl_pkg::in_item_t  byte_data,
    output logic               token_valid,
    input  logic               token_stall,
    output jbl_pkg::out_item_t token_data
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_nonempty;
    jbl_pkg::q_entry_t push_data;
    jbl_pkg::q_entry_t head;

    // Lexer: classifies each byte and builds its result list.
    jbl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Decoupling queue.
    jbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full),
        .pop        (pop),
        .q_nonempty (q_nonempty),
        .head       (head)
    );

    // Output serializer.
    jbl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .head        (head),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

    // The front never writes a full queue.
    `JBL_ASSERT_IMP(a_push_room, push, !q_full)
    // Every queued entry carries between one and four results.
    `JBL_ASSERT_IMP(a_push_count, push, (push_data.count != '0) && (push_data.count <= jbl_pkg::RES_MAX_CNT))
    // The back only retires an entry that is there.
    `JBL_ASSERT_IMP(a_pop_nonempty, pop, q_nonempty)
    // A waiting entry reaches an empty output register in the next cycle.
    `JBL_ASSERT_NXT(a_out_fill, q_nonempty && !token_valid, token_valid)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON byte lexer testbench
// Feeds one continuous JSON text into the lexer: a short directed opening,
// then random token sequences with noise, then a randomly chosen way of
// ending the input. A predictor in the bench tracks lexer state and position,
// queues the token beats each byte should cause, and a checker compares every
// accepted result beat field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    import jbl_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Cycles without any accepted beat before the run is abandoned.
    localparam int STALL_LIMIT = 3000;
    // Quiet cycles after the last expected beat, well beyond the latency.
    localparam int TAIL_CYCLES = 16;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_data;
    logic      token_valid;
    logic      token_stall;
    out_item_t token_data;

    // Predictor state.
    mode_t      lex_state;
    logic [2:0] kw_cand;
    logic [2:0] kw_len;
    pos_t       cur_line;
    pos_t       cur_col;
    pos_t       tok_line;
    pos_t       tok_col;
    logic       text_stopped;

    out_item_t  byte_results[$];
    out_item_t  pending_tokens[$];
    out_item_t  due_token;

    int    burst_left     = 0;
    int    bytes_sent     = 0;
    int    events_checked = 0;
    int    fail_count     = 0;
    int    idle_cycles    = 0;
    string ending_note    = "nothing";

    json_byte_lexer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

    // Clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic string kw_spelling(input int k);
        case (k)
            0:       return "true";
            1:       return "false";
            default: return "null";
        endcase
    endfunction

    function automatic tok_kind_t kw_token(input int k);
        case (k)
            0:       return TK_TRUE;
            1:       return TK_FALSE;
            default: return TK_NULL;
        endcase
    endfunction

    // Decoded byte of an escape, or zero where the escape is not allowed.
    function automatic logic [7:0] escape_value(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return CH_QUOTE;
            CH_BSLASH: return CH_BSLASH;
            "/":       return "/";
            "b":       return 8'd8;
            "f":       return 8'd12;
            "n":       return 8'd10;
            "r":       return 8'd13;
            "t":       return 8'd9;
            default:   return 8'd0;
        endcase
    endfunction

    function void note_result(input logic ev, input tok_kind_t kind, input logic [7:0] val,
                              input pos_t ln, input pos_t col);
        out_item_t r;
        r.event_kind   = ev;
        r.token_kind   = kind;
        r.value_byte   = val;
        r.start_line   = ln;
        r.start_column = col;
        r.last_result  = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    function void close_token(input tok_kind_t kind);
        note_result(EV_DONE, kind, 8'd0, tok_line, tok_col);
        lex_state = MODE_IDLE;
    endfunction

    // Drop every keyword that the new letter rules out.
    function void kw_step(input logic [7:0] c);
        string s;
        for (int k = 0; k < 3; k++)
        begin
            s = kw_spelling(k);
            if (kw_cand[k] && ((int'(kw_len) >= s.len()) || (s[kw_len] != c)))
                kw_cand[k] = 1'b0;
        end
        if (kw_len < 3'd7)
            kw_len = kw_len + 3'd1;
    endfunction

    function tok_kind_t kw_result();
        tok_kind_t kind;
        string     s;
        kind = TK_ERROR;
        for (int k = 2; k >= 0; k--)
        begin
            s = kw_spelling(k);
            if (kw_cand[k] && (int'(kw_len) == s.len()))
                kind = kw_token(k);
        end
        return kind;
    endfunction

    // A byte seen between tokens.
    function void open_token(input logic [7:0] c);
        tok_kind_t kind;
        logic      punct;
        if (!is_space(c))
        begin
            punct = 1'b1;
            kind  = TK_ERROR;
            case (c)
                "{":     kind = TK_LBRACE;
                "}":     kind = TK_RBRACE;
                "[":     kind = TK_LBRACKET;
                "]":     kind = TK_RBRACKET;
                ":":     kind = TK_COLON;
                ",":     kind = TK_COMMA;
                default: punct = 1'b0;
            endcase
            tok_line = cur_line;
            tok_col  = cur_col;
            if (punct)
            begin
                note_result(EV_VALUE, kind, c, tok_line, tok_col);
                close_token(kind);
            end
            else if (c == CH_QUOTE)
                lex_state = MODE_STRING;
            else if ((c == CH_MINUS) || is_digit(c))
            begin
                note_result(EV_VALUE, TK_NUMBER, c, tok_line, tok_col);
                lex_state = MODE_INTEGER;
            end
            else if (is_alpha(c))
            begin
                kw_cand = 3'b111;
                kw_len  = 3'd0;
                kw_step(c);
                note_result(EV_VALUE, TK_ERROR, c, tok_line, tok_col);
                lex_state = MODE_WORD;
            end
            else
            begin
                note_result(EV_VALUE, TK_ERROR, c, tok_line, tok_col);
                close_token(TK_ERROR);
            end
        end
    endfunction

    // Close whatever token is open, then give the end-of-input token.
    function void end_text();
        case (lex_state)
            MODE_STRING, MODE_ESCAPE:    close_token(TK_ERROR);
            MODE_INTEGER, MODE_FRACTION: close_token(TK_NUMBER);
            MODE_WORD:                   close_token(kw_result());
            default:                     ;
        endcase
        lex_state = MODE_IDLE;
        note_result(EV_DONE, TK_EOF, 8'd0, cur_line, cur_col);
        text_stopped = 1'b1;
    endfunction

    function void advance_position(input logic [7:0] c);
        if (c == CH_LF)
        begin
            if (cur_line != POS_MAX)
                cur_line = cur_line + POS_ONE;
            cur_col = POS_ONE;
        end
        else if (cur_col != POS_MAX)
            cur_col = cur_col + POS_ONE;
    endfunction

    // Works out the token beats of one accepted input beat and queues them.
    function void predict_byte(input logic [7:0] c, input logic last);
        logic       reopen;
        logic [7:0] dec;
        out_item_t  tail;
        byte_results.delete();
        reopen = 1'b0;
        if (!text_stopped)
        begin
            if (c == CH_NUL)
                end_text();
            else
            begin
                case (lex_state)
                    MODE_STRING:
                    begin
                        if (c == CH_QUOTE)
                            close_token(TK_STRING);
                        else if (c == CH_BSLASH)
                            lex_state = MODE_ESCAPE;
                        else
                            note_result(EV_VALUE, TK_STRING, c, tok_line, tok_col);
                    end
                    MODE_ESCAPE:
                    begin
                        dec = escape_value(c);
                        if (dec == 8'd0)
                            close_token(TK_ERROR);
                        else
                        begin
                            note_result(EV_VALUE, TK_STRING, dec, tok_line, tok_col);
                            lex_state = MODE_STRING;
                        end
                    end
                    MODE_INTEGER, MODE_FRACTION:
                    begin
                        if (is_digit(c) || ((c == CH_DOT) && (lex_state == MODE_INTEGER)))
                        begin
                            note_result(EV_VALUE, TK_NUMBER, c, tok_line, tok_col);
                            if (c == CH_DOT)
                                lex_state = MODE_FRACTION;
                        end
                        else
                        begin
                            close_token(TK_NUMBER);
                            reopen = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_alpha(c))
                        begin
                            kw_step(c);
                            note_result(EV_VALUE, TK_ERROR, c, tok_line, tok_col);
                        end
                        else
                        begin
                            close_token(kw_result());
                            reopen = 1'b1;
                        end
                    end
                    default:
                    begin
                        lex_state = MODE_IDLE;
                        reopen    = 1'b1;
                    end
                endcase
                if (reopen)
                    open_token(c);
                advance_position(c);
                if (last)
                    end_text();
            end
        end
        if (byte_results.size() > 0)
        begin
            tail = byte_results[byte_results.size() - 1];
            tail.last_result = 1'b1;
            byte_results[byte_results.size() - 1] = tail;
        end
        pending_tokens = {pending_tokens, byte_results};
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Sends one input beat in bursts with random gaps; called at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t beat;
        beat.in_byte     = b;
        beat.end_of_text = last;
        if (burst_left == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        byte_data  <= beat;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // One random token, mostly well formed, sometimes broken or plain noise.
    task automatic send_random_token();
        int         pick;
        int         n;
        int         k;
        logic [7:0] c;
        string      s;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 5))
                0:       c = "{";
                1:       c = "}";
                2:       c = "[";
                3:       c = "]";
                4:       c = ":";
                default: c = ",";
            endcase
            send_byte(c, 1'b0);
        end
        else if (pick < 30)
        begin
            n = $urandom_range(0, 5);
            c = (n == 0) ? CH_SPACE : 8'(8 + n);
            send_byte(c, 1'b0);
        end
        else if (pick < 55)
        begin
            // String with plain bytes, odd bytes and escapes.
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6))
            begin
                n = $urandom_range(0, 9);
                if (n < 2)
                begin
                    send_byte(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 7))
                        0:       c = CH_QUOTE;
                        1:       c = CH_BSLASH;
                        2:       c = "/";
                        3:       c = "b";
                        4:       c = "f";
                        5:       c = "n";
                        6:       c = "r";
                        default: c = "t";
                    endcase
                    send_byte(c, 1'b0);
                end
                else
                begin
                    c = (n == 2) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
                    if ((c == CH_QUOTE) || (c == CH_BSLASH))
                        c = "a";
                    send_byte(c, 1'b0);
                end
            end
            n = $urandom_range(0, 19);
            if (n == 0)
            begin
                send_byte(CH_BSLASH, 1'b0);
                send_byte(8'($urandom_range(0, 1) ? "x" : $urandom_range(1, 31)), 1'b0);
            end
            else if (n != 1)
                send_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 75)
        begin
            // Number: optional minus, digits, optional fraction.
            if ($urandom_range(0, 2) == 0)
                send_byte(CH_MINUS, 1'b0);
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(48, 57)), 1'b0);
            if ($urandom_range(0, 4) < 2)
            begin
                send_byte(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(48, 57)), 1'b0);
            end
        end
        else if (pick < 90)
        begin
            // Keyword, sometimes cut short or run on.
            k = $urandom_range(0, 2);
            s = kw_spelling(k);
            n = $urandom_range(0, 9);
            if (n == 8)
                s = s.substr(0, s.len() - 2);
            for (int i = 0; i < s.len(); i++)
                send_byte(s[i], 1'b0);
            if (n == 9)
                send_byte(8'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                                  : $urandom_range(65, 90)), 1'b0);
        end
        else
            send_byte(8'($urandom_range(1, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All six punctuation tokens back to back.
    task automatic test_punctuation();
        send_text("{}[]:,");
    endtask

    // A signed fraction ended by a following bracket.
    task automatic test_number_end();
        send_text("-7.5]");
    endtask

    // A good escape followed by a bad one inside the same string.
    task automatic test_escapes();
        send_text("\"\\t\\q");
    endtask

    // An unknown letter run ended by a line feed.
    task automatic test_word_run();
        send_text("nulls\n");
    endtask

    // Bytes with the top bit set are stray tokens.
    task automatic test_high_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_keywords();
        send_text("true false");
    endtask

    task automatic test_random_text(input int count);
        int goal;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
            send_random_token();
    endtask

    // The sender holds off until every outstanding token beat has arrived.
    task automatic test_drain_pause();
        byte_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(negedge clk);
        burst_left = $urandom_range(1, 8);
    endtask

    // One of several ways to end the text, then beats that must be ignored.
    task automatic test_end_of_input();
        // Return to idle first so that the chosen ending is reached as meant.
        while (lex_state != MODE_IDLE)
            send_byte(((lex_state == MODE_STRING) || (lex_state == MODE_ESCAPE))
                      ? CH_QUOTE : CH_SPACE, 1'b0);
        case ($urandom_range(0, 4))
            0:
            begin
                ending_note = "the last flag on a brace after a number";
                send_text("12");
                send_byte("{", 1'b1);
            end
            1:
            begin
                ending_note = "the last flag inside a string";
                send_text("\"a");
                send_byte("b", 1'b1);
            end
            2:
            begin
                ending_note = "a zero byte right after a backslash";
                send_text("\"a\\");
                send_byte(CH_NUL, 1'b0);
            end
            3:
            begin
                ending_note = "a zero byte after a keyword";
                send_text("false");
                send_byte(CH_NUL, 1'b0);
            end
            default:
            begin
                ending_note = "the last flag on a line feed";
                send_byte(CH_LF, 1'b1);
            end
        endcase
        send_byte("x", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("{", 1'b1);
        byte_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------
    initial
    begin
        int   phase_left;
        int   stall_mode;
        int   run_left;
        int   tick;
        logic run_level;
        phase_left  = 0;
        stall_mode  = 0;
        run_left    = 0;
        tick        = 0;
        run_level   = 1'b0;
        token_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            tick++;
            case (stall_mode)
                0: token_stall <= 1'b0;
                1: token_stall <= 1'($urandom_range(0, 1));
                2: token_stall <= ((tick % 3) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_level = ~run_level;
                        run_left  = $urandom_range(1, 20);
                    end
                    run_left--;
                    token_stall <= run_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token beat with no event due: kind %0d", token_data.token_kind);
                fail_count++;
            end
            else
            begin
                due_token = pending_tokens.pop_front();
                events_checked++;
                if (token_data.event_kind !== due_token.event_kind)
                begin
                    $error("event_kind: expected %0d, got %0d",
                           due_token.event_kind, token_data.event_kind);
                    fail_count++;
                end
                if (token_data.token_kind !== due_token.token_kind)
                begin
                    $error("token_kind: expected %0d, got %0d",
                           due_token.token_kind, token_data.token_kind);
                    fail_count++;
                end
                if (token_data.value_byte !== due_token.value_byte)
                begin
                    $error("value_byte: expected 0x%02h, got 0x%02h",
                           due_token.value_byte, token_data.value_byte);
                    fail_count++;
                end
                if (token_data.start_line !== due_token.start_line)
                begin
                    $error("start_line: expected %0d, got %0d",
                           due_token.start_line, token_data.start_line);
                    fail_count++;
                end
                if (token_data.start_column !== due_token.start_column)
                begin
                    $error("start_column: expected %0d, got %0d",
                           due_token.start_column, token_data.start_column);
                    fail_count++;
                end
                if (token_data.last_result !== due_token.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           due_token.last_result, token_data.last_result);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles, %0d events still due",
                         STALL_LIMIT, pending_tokens.size());
                $display("** json_byte_lexer: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_data    = '0;
        lex_state    = MODE_IDLE;
        kw_cand      = 3'b111;
        kw_len       = 3'd0;
        cur_line     = POS_ONE;
        cur_col      = POS_ONE;
        tok_line     = '0;
        tok_col      = '0;
        text_stopped = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_punctuation();
        test_number_end();
        test_escapes();
        test_word_run();
        test_high_bytes();
        test_keywords();
        test_random_text(160);
        test_drain_pause();
        test_random_text(160);
        test_end_of_input();

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d token beats over punctuation, strings,",
                 bytes_sent, events_checked);
        $display("escapes, numbers, keywords and stray bytes; input ended by %s.",
                 ending_note);
        if (fail_count == 0)
            $display("** json_byte_lexer: PASSED **");
        else
            $display("** json_byte_lexer: FAILED **");
        $finish;
    end

endmodule
